/* rtl/pwls_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwls_pkg: piecewise linear saturation package
// Request and response types, data width and region codes.
// ----------------------------------------------------------------------------
package pwls_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned HALF_WIDTH = (DATA_WIDTH + 1) / 2;
  localparam int unsigned HIGH_WIDTH = DATA_WIDTH - HALF_WIDTH;
  localparam int unsigned LATENCY    = DATA_WIDTH + 5;

  typedef enum logic [1:0] {
    REGION_BELOW = 2'd0,
    REGION_RAMP  = 2'd1,
    REGION_ABOVE = 2'd2
  } region_e;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sample;
    logic signed [DATA_WIDTH-1:0] lower_break;
    logic signed [DATA_WIDTH-1:0] upper_break;
    logic signed [DATA_WIDTH-1:0] low_level;
    logic signed [DATA_WIDTH-1:0] high_level;
  } pwls_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result;
    region_e                      region;
  } pwls_rsp_t;

endpackage
`default_nettype wire

/* rtl/piecewise_linear_saturation_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_saturation_core: clamped linear interpolation ramp
// Pipelined ramp with split multiply and one divider stage per quotient bit.
// ----------------------------------------------------------------------------
// A request is taken whenever start is high; busy stays low, so one request
// per cycle streams through. Each request gives exactly one response, shown
// on rsp_o with done_o high for one cycle, after acceptance and in request
// order. The restoring divider resolves one quotient bit per pipeline stage,
// after four stages of compare, magnitude, partial products and product sum.
// The receiver cannot stall, so responses must be taken when shown.
module piecewise_linear_saturation_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire pwls_pkg::pwls_req_t req_i,
  output logic                    done_o,
  output pwls_pkg::pwls_rsp_t     rsp_o
);
  import pwls_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  // stage 1: compare and differences
  logic          above;
  logic          ramp;
  logic [W:0]    diff_n;
  logic [W:0]    diff_d;
  logic [W:0]    diff_y;

  logic          s1_valid_q;
  region_e       s1_region_q;
  logic [W-1:0]  s1_base_q;
  logic [W:0]    s1_dy_q;
  logic [W-1:0]  s1_n_q;
  logic [W-1:0]  s1_d_q;

  // stage 2: slope magnitude
  logic [W:0]    dy_abs;
  logic          s2_valid_q;
  region_e       s2_region_q;
  logic [W-1:0]  s2_base_q;
  logic          s2_neg_q;
  logic [W-1:0]  s2_m_q;
  logic [W-1:0]  s2_n_q;
  logic [W-1:0]  s2_d_q;

  // stage 3: partial products
  logic [W+HALF_WIDTH-1:0] pp_lo_d;
  logic [W+HIGH_WIDTH-1:0] pp_hi_d;
  logic                    s3_valid_q;
  region_e                 s3_region_q;
  logic [W-1:0]            s3_base_q;
  logic                    s3_neg_q;
  logic [W-1:0]            s3_d_q;
  logic [W+HALF_WIDTH-1:0] s3_pp_lo_q;
  logic [W+HIGH_WIDTH-1:0] s3_pp_hi_q;

  // stage 4 and divider stages
  logic [2*W-1:0] prod;
  logic           div_valid_q  [W+1];
  region_e        div_region_q [W+1];
  logic [W-1:0]   div_base_q   [W+1];
  logic           div_neg_q    [W+1];
  logic [W-1:0]   div_d_q      [W+1];
  logic [W-1:0]   div_rem_q    [W+1];
  logic [W-1:0]   div_low_q    [W+1];
  logic [W-1:0]   div_quo_q    [W+1];

  // output stage
  logic [W:0]     quo_ext;
  logic [W:0]     sum;
  logic [W-1:0]   sat;
  logic           done_q;
  pwls_rsp_t      rsp_q;

  assign busy = 1'b0;

  assign above  = req_i.sample > req_i.upper_break;
  assign ramp   = !above && (req_i.sample > req_i.lower_break);
  assign diff_n = {req_i.sample[W-1], req_i.sample}
                - {req_i.lower_break[W-1], req_i.lower_break};
  assign diff_d = {req_i.upper_break[W-1], req_i.upper_break}
                - {req_i.lower_break[W-1], req_i.lower_break};
  assign diff_y = {req_i.high_level[W-1], req_i.high_level}
                - {req_i.low_level[W-1], req_i.low_level};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_region_q <= above ? REGION_ABOVE : (ramp ? REGION_RAMP : REGION_BELOW);
    s1_base_q   <= above ? req_i.high_level : req_i.low_level;
    s1_dy_q     <= diff_y;
    s1_n_q      <= diff_n[W-1:0];
    s1_d_q      <= ramp ? diff_d[W-1:0] : {{(W-1){1'b0}}, 1'b1};
  end

  assign dy_abs = s1_dy_q[W] ? -s1_dy_q : s1_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_region_q <= s1_region_q;
    s2_base_q   <= s1_base_q;
    s2_neg_q    <= s1_dy_q[W];
    s2_m_q      <= (s1_region_q == REGION_RAMP) ? dy_abs[W-1:0] : '0;
    s2_n_q      <= s1_n_q;
    s2_d_q      <= s1_d_q;
  end

  assign pp_lo_d = {{HALF_WIDTH{1'b0}}, s2_m_q} * {{W{1'b0}}, s2_n_q[HALF_WIDTH-1:0]};
  assign pp_hi_d = {{HIGH_WIDTH{1'b0}}, s2_m_q} * {{W{1'b0}}, s2_n_q[W-1:HALF_WIDTH]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_region_q <= s2_region_q;
    s3_base_q   <= s2_base_q;
    s3_neg_q    <= s2_neg_q;
    s3_d_q      <= s2_d_q;
    s3_pp_lo_q  <= pp_lo_d;
    s3_pp_hi_q  <= pp_hi_d;
  end

  assign prod = {s3_pp_hi_q, {HALF_WIDTH{1'b0}}} + {{HIGH_WIDTH{1'b0}}, s3_pp_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_valid_q[0] <= 1'b0;
    end else begin
      div_valid_q[0] <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    div_region_q[0] <= s3_region_q;
    div_base_q[0]   <= s3_base_q;
    div_neg_q[0]    <= s3_neg_q;
    div_d_q[0]      <= s3_d_q;
    div_rem_q[0]    <= prod[2*W-1:W];
    div_low_q[0]    <= prod[W-1:0];
    div_quo_q[0]    <= '0;
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 1; k <= W; k++) begin : g_div
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    assign trial = {div_rem_q[k-1], div_low_q[k-1][W-1]};
    assign diff  = trial - {1'b0, div_d_q[k-1]};
    assign ge    = trial >= {1'b0, div_d_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_valid_q[k] <= 1'b0;
      end else begin
        div_valid_q[k] <= div_valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      div_region_q[k] <= div_region_q[k-1];
      div_base_q[k]   <= div_base_q[k-1];
      div_neg_q[k]    <= div_neg_q[k-1];
      div_d_q[k]      <= div_d_q[k-1];
      div_rem_q[k]    <= ge ? diff[W-1:0] : trial[W-1:0];
      div_low_q[k]    <= {div_low_q[k-1][W-2:0], 1'b0};
      div_quo_q[k]    <= {div_quo_q[k-1][W-2:0], ge};
    end
  end

  assign quo_ext = {1'b0, div_quo_q[W]};
  assign sum     = {div_base_q[W][W-1], div_base_q[W]}
                 + (div_neg_q[W] ? -quo_ext : quo_ext);

  always_comb begin
    if (sum[W] != sum[W-1]) begin
      sat = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      sat = sum[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_valid_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q.result <= sat;
    rsp_q.region <= div_region_q[W];
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY done_o)
    else $error("response missing after request");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("response without request");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid_q[W] |-> div_rem_q[W] < div_d_q[W])
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire
